// File: sv/absolute_value_priority_heap_macros.svh
// Assertion macros shared by the heap block.
`ifndef ABSOLUTE_VALUE_PRIORITY_HEAP_MACROS_SVH
`define ABSOLUTE_VALUE_PRIORITY_HEAP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define AVPH_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("heap assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define AVPH_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("heap assertion failed");

`endif

// File: sv/avph_pkg.sv
`timescale 1ns / 1ps

package avph_pkg;

    localparam int CAPACITY = 1024;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = IDX_W + 2;

    typedef logic [DATA_W-1:0]  t_data;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [CHILD_W-1:0] t_child;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // capture the input value
        logic push_begin;  // open a hole at the end of the heap
        logic set_ovf;     // record a dropped push
        logic up_read;     // read the parent of the hole
        logic up_step;     // move the parent down into the hole
        logic write_x;     // place the held value into the hole
        logic pop_read;    // read the root and the last entry
        logic pop_load;    // present the pop result and start the descent
        logic dn_read;     // read both children of the hole
        logic dn_step;     // move the better child up into the hole
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_zero;
        logic full;
        logic empty;
        logic single;
        logic pos_zero;
        logic up_move;
        logic dn_move;
        logic out_free;
    } t_stat;

    // True when a must leave the store before b.
    function automatic logic ranks_before(t_data a, t_data b);
        t_data ma;
        t_data mb;
        ma = a[DATA_W-1] ? t_data'(~a + 1'b1) : a;
        mb = b[DATA_W-1] ? t_data'(~b + 1'b1) : b;
        if (ma != mb) begin
            return ma < mb;
        end
        return $signed(a) < $signed(b);
    endfunction

endpackage

// File: sv/avph_dpath.sv
`timescale 1ns / 1ps

module avph_dpath
    import avph_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [31:0] i_value,
    input  logic        i_ready,
    output t_stat       o_stat,
    output logic        o_valid,
    output logic [31:0] o_popped_value,
    output logic        o_was_empty,
    output logic        o_overflow_seen
);

    t_data  r_mem [CAPACITY];
    t_data  r_rd_a;
    t_data  r_rd_b;
    t_data  r_x;
    t_idx   r_pos;
    t_cnt   r_count;
    logic   r_ovf;
    logic   r_out_valid;
    t_data  r_out_value;
    logic   r_out_empty;
    logic   r_out_ovf;

    t_idx   parent;
    t_child left;
    t_child right;
    t_child count_ext;
    logic   left_ok;
    logic   right_ok;
    logic   take_left;
    logic   take_right;
    t_child child;
    t_data  child_value;
    t_idx   last_idx;
    logic   rd_en;
    t_idx   rd_addr_a;
    t_idx   rd_addr_b;
    logic   wr_en;
    t_data  wr_data;

    assign parent    = t_idx'((r_pos - 1'b1) >> 1);
    assign left      = {1'b0, r_pos, 1'b1};
    assign right     = left + CHILD_W'(1);
    assign count_ext = CHILD_W'(r_count);
    assign left_ok   = left < count_ext;
    assign right_ok  = right < count_ext;
    assign last_idx  = t_idx'(r_count - 1'b1);

    // Three comparisons side by side, then a selection.
    assign take_left   = left_ok && ranks_before(r_rd_a, r_x);
    assign take_right  = right_ok && (take_left ? ranks_before(r_rd_b, r_rd_a)
                                                : ranks_before(r_rd_b, r_x));
    assign child       = take_right ? right : left;
    assign child_value = take_right ? r_rd_b : r_rd_a;

    assign rd_en     = i_cmd.up_read | i_cmd.pop_read | i_cmd.dn_read;
    assign rd_addr_a = i_cmd.pop_read ? '0 : (i_cmd.up_read ? parent : left[IDX_W-1:0]);
    assign rd_addr_b = i_cmd.pop_read ? last_idx : right[IDX_W-1:0];
    assign wr_en     = i_cmd.up_step | i_cmd.write_x | i_cmd.dn_step;
    assign wr_data   = i_cmd.up_step ? r_rd_a : (i_cmd.dn_step ? child_value : r_x);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_pos] <= wr_data;
        end
        if (rd_en) begin
            r_rd_a <= r_mem[rd_addr_a];
            r_rd_b <= r_mem[rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push_begin) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.pop_load && r_count != '0) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end else if (i_cmd.pop_load) begin
                r_ovf <= 1'b0;
            end
            if (i_cmd.pop_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x <= i_value;
        end else if (i_cmd.pop_load) begin
            r_x <= r_rd_b;
        end
        if (i_cmd.push_begin) begin
            r_pos <= r_count[IDX_W-1:0];
        end else if (i_cmd.up_step) begin
            r_pos <= parent;
        end else if (i_cmd.pop_load) begin
            r_pos <= '0;
        end else if (i_cmd.dn_step) begin
            r_pos <= child[IDX_W-1:0];
        end
        if (i_cmd.pop_load) begin
            r_out_empty <= (r_count == '0);
            r_out_value <= (r_count == '0) ? '0 : r_rd_a;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_stat.in_zero  = (i_value == '0);
    assign o_stat.full     = (r_count == CNT_W'(CAPACITY));
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.single   = (r_count == CNT_W'(1));
    assign o_stat.pos_zero = (r_pos == '0);
    assign o_stat.up_move  = ranks_before(r_x, r_rd_a);
    assign o_stat.dn_move  = take_left | take_right;
    assign o_stat.out_free = !r_out_valid || i_ready;

    assign o_valid         = r_out_valid;
    assign o_popped_value  = r_out_value;
    assign o_was_empty     = r_out_empty;
    assign o_overflow_seen = r_out_ovf;

endmodule

// File: sv/avph_ctrl.sv
`timescale 1ns / 1ps

module avph_ctrl
    import avph_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_stat i_stat,
    output logic  o_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_UP_CHK = 7'b0000010,
        S_UP_CMP = 7'b0000100,
        S_POP_RD = 7'b0001000,
        S_POP_LD = 7'b0010000,
        S_DN_RD  = 7'b0100000,
        S_DN_CMP = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.in_zero) begin
                        n_state = S_POP_RD;
                    end else if (i_stat.full) begin
                        o_cmd.set_ovf = 1'b1;
                    end else begin
                        o_cmd.push_begin = 1'b1;
                        n_state          = S_UP_CHK;
                    end
                end
            end
            S_UP_CHK: begin
                if (i_stat.pos_zero) begin
                    o_cmd.write_x = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.up_read = 1'b1;
                    n_state       = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.up_move) begin
                    o_cmd.up_step = 1'b1;
                    n_state       = S_UP_CHK;
                end else begin
                    o_cmd.write_x = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_POP_RD: begin
                o_cmd.pop_read = 1'b1;
                n_state        = S_POP_LD;
            end
            S_POP_LD: begin
                if (i_stat.out_free) begin
                    o_cmd.pop_load = 1'b1;
                    n_state = (i_stat.empty || i_stat.single) ? S_IDLE : S_DN_RD;
                end
            end
            S_DN_RD: begin
                o_cmd.dn_read = 1'b1;
                n_state       = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (i_stat.dn_move) begin
                    o_cmd.dn_step = 1'b1;
                    n_state       = S_DN_RD;
                end else begin
                    o_cmd.write_x = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: sv/absolute_value_priority_heap.sv
`timescale 1ns / 1ps

// Priority store of signed 32-bit values, kept as a binary min-heap in a single
// on-chip memory of CAPACITY entries and ordered by magnitude, with the smaller
// signed value first on equal magnitude (the magnitude of -2^31 counts as 2^31).
// A nonzero input value is inserted and gives no result; a zero input removes
// the entry of least magnitude and gives one result, which carries 0 and the
// empty flag when the store holds nothing. A push into a full store is dropped
// and sets an overflow mark, reported and cleared by the next pop result.
// Items are worked one at a time. A push opens a hole at the end of the heap,
// then at each level reads the parent and moves it down into the hole; the value
// is placed once it no longer ranks before the parent or the hole is the root.
// A pop reads the root and the last entry, waits until the output register is
// free, presents the result and, when two or more entries were held, lets the
// last entry descend: at each level it reads both children and moves the better
// one up, or places the value once neither child ranks before it. Each level
// needs a registered read, then a compare and a write. The heap memory needs no
// clearing after reset, because only entries below the fill count are ever used.
// A finished pop result waits in the output register while further pushes are
// taken; a second pop waits until that result has been transferred.
module absolute_value_priority_heap
    import avph_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_popped_value,
    output logic        o_was_empty,
    output logic        o_overflow_seen
);

`include "absolute_value_priority_heap_macros.svh"

    t_cmd  cmd;
    t_stat stat;

    // The controller sequences each insertion or removal level by level.
    avph_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    // The datapath holds the heap memory, the fill count, the moving value and
    // the output register.
    avph_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_value         (i_value),
        .i_ready         (i_ready),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_popped_value  (o_popped_value),
        .o_was_empty     (o_was_empty),
        .o_overflow_seen (o_overflow_seen)
    );

    // A pop result is never written over one that has not yet been transferred.
    `AVPH_ASSERT_IMP(a_no_result_overwrite, cmd.pop_load, (!o_valid || i_ready))
    // An insertion is never started into a full store.
    `AVPH_ASSERT_IMP(a_no_push_when_full, cmd.push_begin, !stat.full)
    // A new result appears only after the controller has loaded one.
    `AVPH_ASSERT_NXT(a_result_from_pop, (!o_valid && !cmd.pop_load), !o_valid)

endmodule
